### src/polygon_centroid_core_macros.svh
// Assertion macros used by the polygon centroid checker.
`ifndef POLYGON_CENTROID_CORE_MACROS_SVH
`define POLYGON_CENTROID_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define PCC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define PCC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### src/pcc_pkg.sv
// Shared constants, types and status codes of the polygon centroid core.
package pcc_pkg;

    localparam int MAX_VERTICES = 1024;
    localparam int CNT_W        = $clog2(MAX_VERTICES + 2);
    localparam int COORD_W      = 16;
    localparam int PSUM_W       = COORD_W + 1;
    localparam int PROD_W       = 2 * COORD_W;
    localparam int CROSS_W      = PROD_W + 1;
    localparam int WPROD_W      = CROSS_W + PSUM_W;
    localparam int AREA_W       = 43;
    localparam int WSUM_W       = 60;
    localparam int DIVR_W       = AREA_W + 2;
    localparam int QSTEP_W      = $clog2(WSUM_W);
    localparam int STATUS_W     = 2;
    localparam int FIFO_DEPTH   = 4;
    localparam int FIFO_AW      = $clog2(FIFO_DEPTH);

    localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_ZERO_AREA = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_OVERFLOW  = 2'd2;

    // One edge request from the front to the back.
    typedef struct packed {
        logic signed [COORD_W-1:0] xa;
        logic signed [COORD_W-1:0] ya;
        logic signed [COORD_W-1:0] xb;
        logic signed [COORD_W-1:0] yb;
        logic                      close;
        logic                      ovf;
    } t_edge;

    // Division request to the shared divider.
    typedef struct packed {
        logic              start;
        logic              neg;
        logic [WSUM_W-1:0] dividend;
        logic [DIVR_W-1:0] divisor;
    } t_div_req;

endpackage

### src/polygon_centroid_core.sv
// Polygon centroid core: one vertex per cycle, one centroid result per closed polygon.
// Throughput: one vertex per cycle while the 4-entry edge queue has room; once it fills, the
//   input stalls while the back end divides; it also stalls after a last vertex until the
//   closing edge of a polygon of 2 to 1024 vertices is queued. Results pass the 3-stage edge
//   pipeline, then two 60-step divisions on one radix-2 divider, skipped for errors.
// Reset: synchronous, active low; clears counters, accumulators and all valid flags.
module polygon_centroid_core import pcc_pkg::*; (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  logic signed [COORD_W-1:0] i_vertex_x,
    input  logic signed [COORD_W-1:0] i_vertex_y,
    input  logic                      i_last,
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output logic signed [COORD_W-1:0] o_centroid_x,
    output logic signed [COORD_W-1:0] o_centroid_y,
    output logic signed [AREA_W-1:0]  o_area_doubled,
    output logic [STATUS_W-1:0]       o_status
);

    logic                      q_push;
    logic                      q_pop;
    logic                      q_full;
    logic                      q_empty;
    t_edge                     q_wr_edge;
    t_edge                     q_rd_edge;
    t_div_req                  div_req;
    logic                      div_done;
    logic signed [COORD_W-1:0] div_quot;

    pcc_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_in_valid),
        .i_vertex_x (i_vertex_x),
        .i_vertex_y (i_vertex_y),
        .i_last     (i_last),
        .o_stall    (o_in_stall),
        .i_q_full   (q_full),
        .o_push     (q_push),
        .o_edge     (q_wr_edge)
    );

    pcc_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_wr_edge),
        .i_pop   (q_pop),
        .o_data  (q_rd_edge),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    pcc_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_edge         (q_rd_edge),
        .i_q_empty      (q_empty),
        .o_pop          (q_pop),
        .o_div_req      (div_req),
        .i_div_done     (div_done),
        .i_div_quot     (div_quot),
        .o_valid        (o_out_valid),
        .i_stall        (i_out_stall),
        .o_centroid_x   (o_centroid_x),
        .o_centroid_y   (o_centroid_y),
        .o_area_doubled (o_area_doubled),
        .o_status       (o_status)
    );

    pcc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

endmodule

### src/pcc_front.sv
// Front end: accepts vertices, tracks first/previous vertex and count, issues edge requests.
module pcc_front import pcc_pkg::*; (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    input  logic signed [COORD_W-1:0] i_vertex_x,
    input  logic signed [COORD_W-1:0] i_vertex_y,
    input  logic                      i_last,
    output logic                      o_stall,
    input  logic                      i_q_full,
    output logic                      o_push,
    output t_edge                     o_edge
);

    logic [CNT_W-1:0]          r_count, n_count;
    logic signed [COORD_W-1:0] r_first_x, n_first_x, r_first_y, n_first_y;
    logic signed [COORD_W-1:0] r_prev_x, n_prev_x, r_prev_y, n_prev_y;
    logic                      r_close_pend, n_close_pend;
    t_edge                     r_close_edge, n_close_edge;
    logic                      accept;

    assign o_stall = r_close_pend | i_q_full;
    assign accept  = i_valid & ~o_stall;

    always_comb begin
        n_count      = r_count;
        n_first_x    = r_first_x;
        n_first_y    = r_first_y;
        n_prev_x     = r_prev_x;
        n_prev_y     = r_prev_y;
        n_close_pend = r_close_pend;
        n_close_edge = r_close_edge;
        o_push       = 1'b0;
        o_edge       = '0;
        if (r_close_pend && !i_q_full) begin
            o_push       = 1'b1;
            o_edge       = r_close_edge;
            n_close_pend = 1'b0;
        end else if (accept) begin
            if (r_count < CNT_W'(MAX_VERTICES)) begin
                if (r_count == '0) begin
                    n_first_x = i_vertex_x;
                    n_first_y = i_vertex_y;
                end else begin
                    o_push    = 1'b1;
                    o_edge.xa = r_prev_x;
                    o_edge.ya = r_prev_y;
                    o_edge.xb = i_vertex_x;
                    o_edge.yb = i_vertex_y;
                end
                n_prev_x = i_vertex_x;
                n_prev_y = i_vertex_y;
                n_count  = r_count + 1'b1;
            end else begin
                n_count = CNT_W'(MAX_VERTICES + 1);
            end
            if (i_last) begin
                n_count = '0;
                if (r_count >= CNT_W'(MAX_VERTICES)) begin
                    // overflow marker closes the polygon with no geometry
                    o_push       = 1'b1;
                    o_edge       = '0;
                    o_edge.close = 1'b1;
                    o_edge.ovf   = 1'b1;
                end else if (r_count == '0) begin
                    // single vertex: degenerate closing edge
                    o_push       = 1'b1;
                    o_edge.xa    = i_vertex_x;
                    o_edge.ya    = i_vertex_y;
                    o_edge.xb    = i_vertex_x;
                    o_edge.yb    = i_vertex_y;
                    o_edge.close = 1'b1;
                    o_edge.ovf   = 1'b0;
                end else begin
                    // hold the closing edge until the queue has room
                    n_close_pend       = 1'b1;
                    n_close_edge.xa    = i_vertex_x;
                    n_close_edge.ya    = i_vertex_y;
                    n_close_edge.xb    = r_first_x;
                    n_close_edge.yb    = r_first_y;
                    n_close_edge.close = 1'b1;
                    n_close_edge.ovf   = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count      <= '0;
            r_first_x    <= '0;
            r_first_y    <= '0;
            r_prev_x     <= '0;
            r_prev_y     <= '0;
            r_close_pend <= 1'b0;
        end else begin
            r_count      <= n_count;
            r_first_x    <= n_first_x;
            r_first_y    <= n_first_y;
            r_prev_x     <= n_prev_x;
            r_prev_y     <= n_prev_y;
            r_close_pend <= n_close_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        r_close_edge <= n_close_edge;
    end

endmodule

### src/pcc_fifo.sv
// Short edge request queue between the front and the back.
module pcc_fifo import pcc_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_edge i_data,
    input  logic  i_pop,
    output t_edge o_data,
    output logic  o_full,
    output logic  o_empty
);

    t_edge              r_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0] r_wr_ptr;
    logic [FIFO_AW-1:0] r_rd_ptr;
    logic [FIFO_AW:0]   r_count;
    logic               do_push;
    logic               do_pop;

    assign o_full  = (r_count == (FIFO_AW + 1)'(FIFO_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign do_push = i_push & ~o_full;
    assign do_pop  = i_pop & ~o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

### src/pcc_div.sv
// Radix-2 restoring divider on magnitudes, with signed saturation of the quotient.
module pcc_div import pcc_pkg::*; (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  t_div_req                  i_req,
    output logic                      o_done,
    output logic signed [COORD_W-1:0] o_quot
);

    logic               r_busy;
    logic               r_done;
    logic [QSTEP_W-1:0] r_step;
    logic [DIVR_W-1:0]  r_rem;
    logic [WSUM_W-1:0]  r_quo;
    logic [DIVR_W-1:0]  r_divisor;
    logic               r_neg;
    logic [DIVR_W:0]    shifted;
    logic [DIVR_W+1:0]  diff;
    logic               qbit;

    assign shifted = {r_rem, r_quo[WSUM_W-1]};
    assign diff    = {1'b0, shifted} - {2'b00, r_divisor};
    assign qbit    = ~diff[DIVR_W+1];
    assign o_done  = r_done;

    always_comb begin
        if (r_neg) begin
            if (r_quo > WSUM_W'(2 ** (COORD_W - 1))) begin
                o_quot = {1'b1, {(COORD_W - 1){1'b0}}};
            end else begin
                o_quot = -$signed(r_quo[COORD_W-1:0]);
            end
        end else begin
            if (r_quo > WSUM_W'(2 ** (COORD_W - 1) - 1)) begin
                o_quot = {1'b0, {(COORD_W - 1){1'b1}}};
            end else begin
                o_quot = $signed(r_quo[COORD_W-1:0]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                r_step <= r_step + 1'b1;
                if (r_step == QSTEP_W'(WSUM_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem     <= '0;
            r_quo     <= i_req.dividend;
            r_divisor <= i_req.divisor;
            r_neg     <= i_req.neg;
        end else if (r_busy) begin
            r_rem <= qbit ? diff[DIVR_W-1:0] : shifted[DIVR_W-1:0];
            r_quo <= {r_quo[WSUM_W-2:0], qbit};
        end
    end

endmodule

### src/pcc_back.sv
// Back end: edge multiply-accumulate pipeline, division sequencing and result register.
module pcc_back import pcc_pkg::*; (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  t_edge                      i_edge,
    input  logic                       i_q_empty,
    output logic                       o_pop,
    output t_div_req                   o_div_req,
    input  logic                       i_div_done,
    input  logic signed [COORD_W-1:0]  i_div_quot,
    output logic                       o_valid,
    input  logic                       i_stall,
    output logic signed [COORD_W-1:0]  o_centroid_x,
    output logic signed [COORD_W-1:0]  o_centroid_y,
    output logic signed [AREA_W-1:0]   o_area_doubled,
    output logic [STATUS_W-1:0]        o_status
);

    typedef enum logic [2:0] {
        S_ACC,
        S_DRAIN,
        S_PREP,
        S_DIVX,
        S_DIVY,
        S_OUT
    } t_state;

    t_state r_state;

    // stage A: products and coordinate sums
    logic                      r_a_valid, r_a_close, r_a_ovf;
    logic signed [PROD_W-1:0]  r_p1, r_p2;
    logic signed [PSUM_W-1:0]  r_a_sx, r_a_sy;
    // stage B: cross product
    logic                      r_b_valid, r_b_close, r_b_ovf;
    logic signed [CROSS_W-1:0] r_b_cross;
    logic signed [PSUM_W-1:0]  r_b_sx, r_b_sy;
    // stage C: weighted products
    logic                      r_c_valid, r_c_close, r_c_ovf;
    logic signed [CROSS_W-1:0] r_c_cross;
    logic signed [WPROD_W-1:0] r_wx, r_wy;
    // accumulators
    logic signed [AREA_W-1:0]  r_area;
    logic signed [WSUM_W-1:0]  r_wx_sum, r_wy_sum;

    logic                      r_ovf;
    logic                      r_area_neg;
    t_div_req                  r_div_req;
    logic                      r_out_valid;
    logic signed [COORD_W-1:0] r_out_cx, r_out_cy;
    logic signed [AREA_W-1:0]  r_out_area;
    logic [STATUS_W-1:0]       r_out_status;

    logic                      out_accept;
    logic [AREA_W-1:0]         area_mag;
    logic [DIVR_W-1:0]         divisor;
    logic [WSUM_W-1:0]         wx_mag, wy_mag;

    assign o_pop          = (r_state == S_ACC) && !i_q_empty;
    assign out_accept     = r_out_valid && !i_stall;
    assign o_valid        = r_out_valid;
    assign o_centroid_x   = r_out_cx;
    assign o_centroid_y   = r_out_cy;
    assign o_area_doubled = r_out_area;
    assign o_status       = r_out_status;
    assign o_div_req      = r_div_req;

    assign area_mag = r_area[AREA_W-1] ? (~r_area + 1'b1) : r_area;
    assign divisor  = {2'b00, area_mag} + {1'b0, area_mag, 1'b0};
    assign wx_mag   = r_wx_sum[WSUM_W-1] ? (~r_wx_sum + 1'b1) : r_wx_sum;
    assign wy_mag   = r_wy_sum[WSUM_W-1] ? (~r_wy_sum + 1'b1) : r_wy_sum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
        end else begin
            r_a_valid <= o_pop;
            r_b_valid <= r_a_valid;
            r_c_valid <= r_b_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a_close <= i_edge.close;
        r_a_ovf   <= i_edge.ovf;
        r_p1      <= i_edge.xa * i_edge.yb;
        r_p2      <= i_edge.xb * i_edge.ya;
        r_a_sx    <= $signed({i_edge.xa[COORD_W-1], i_edge.xa})
                   + $signed({i_edge.xb[COORD_W-1], i_edge.xb});
        r_a_sy    <= $signed({i_edge.ya[COORD_W-1], i_edge.ya})
                   + $signed({i_edge.yb[COORD_W-1], i_edge.yb});
        r_b_close <= r_a_close;
        r_b_ovf   <= r_a_ovf;
        r_b_cross <= $signed({r_p1[PROD_W-1], r_p1}) - $signed({r_p2[PROD_W-1], r_p2});
        r_b_sx    <= r_a_sx;
        r_b_sy    <= r_a_sy;
        r_c_close <= r_b_close;
        r_c_ovf   <= r_b_ovf;
        r_c_cross <= r_b_cross;
        r_wx      <= r_b_cross * r_b_sx;
        r_wy      <= r_b_cross * r_b_sy;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || out_accept) begin
            r_area   <= '0;
            r_wx_sum <= '0;
            r_wy_sum <= '0;
        end else if (r_c_valid) begin
            r_area   <= r_area + AREA_W'(r_c_cross);
            r_wx_sum <= r_wx_sum + WSUM_W'(r_wx);
            r_wy_sum <= r_wy_sum + WSUM_W'(r_wy);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= S_ACC;
            r_out_valid     <= 1'b0;
            r_div_req.start <= 1'b0;
        end else begin
            r_div_req.start <= 1'b0;
            case (r_state)
                S_ACC: begin
                    if (o_pop && i_edge.close) begin
                        r_state <= S_DRAIN;
                    end
                end
                S_DRAIN: begin
                    // wait for the closing edge to reach the accumulators
                    if (r_c_valid && r_c_close) begin
                        r_ovf   <= r_c_ovf;
                        r_state <= S_PREP;
                    end
                end
                S_PREP: begin
                    if (r_ovf || r_area == '0) begin
                        r_out_cx     <= '0;
                        r_out_cy     <= '0;
                        r_out_area   <= '0;
                        r_out_status <= r_ovf ? STATUS_OVERFLOW : STATUS_ZERO_AREA;
                        r_out_valid  <= 1'b1;
                        r_state      <= S_OUT;
                    end else begin
                        r_area_neg         <= r_area[AREA_W-1];
                        r_div_req.start    <= 1'b1;
                        r_div_req.neg      <= r_wx_sum[WSUM_W-1] ^ r_area[AREA_W-1];
                        r_div_req.dividend <= wx_mag;
                        r_div_req.divisor  <= divisor;
                        r_state            <= S_DIVX;
                    end
                end
                S_DIVX: begin
                    if (i_div_done) begin
                        r_out_cx           <= i_div_quot;
                        r_div_req.start    <= 1'b1;
                        r_div_req.neg      <= r_wy_sum[WSUM_W-1] ^ r_area_neg;
                        r_div_req.dividend <= wy_mag;
                        r_state            <= S_DIVY;
                    end
                end
                S_DIVY: begin
                    if (i_div_done) begin
                        r_out_cy     <= i_div_quot;
                        r_out_area   <= r_area;
                        r_out_status <= STATUS_OK;
                        r_out_valid  <= 1'b1;
                        r_state      <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (!i_stall) begin
                        r_out_valid <= 1'b0;
                        r_state     <= S_ACC;
                    end
                end
                default: begin
                    r_state <= S_ACC;
                end
            endcase
        end
    end

endmodule

### src/pcc_checker.sv
// Port-level checker for the polygon centroid core, bound to the top level.
`include "polygon_centroid_core_macros.svh"

module pcc_checker import pcc_pkg::*; (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      o_out_valid,
    input logic                      i_out_stall,
    input logic signed [COORD_W-1:0] o_centroid_x,
    input logic signed [COORD_W-1:0] o_centroid_y,
    input logic signed [AREA_W-1:0]  o_area_doubled,
    input logic [STATUS_W-1:0]       o_status
);

    logic out_stalled;
    logic out_taken;
    logic not_ok;
    logic is_ok;
    logic fields_zero;
    logic [2*COORD_W+AREA_W+STATUS_W-1:0] out_payload;

    assign out_stalled = o_out_valid && i_out_stall;
    assign out_taken   = o_out_valid && !i_out_stall;
    assign not_ok      = o_out_valid && (o_status != STATUS_OK);
    assign is_ok       = o_out_valid && (o_status == STATUS_OK);
    assign fields_zero = (o_centroid_x == '0) && (o_centroid_y == '0) && (o_area_doubled == '0);
    assign out_payload = {o_centroid_x, o_centroid_y, o_area_doubled, o_status};

    // hold a stalled result
    `PCC_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, out_stalled, o_out_valid && $stable(out_payload), "stalled result changed")
    // error results carry no geometry
    `PCC_ASSERT_NOW(a_err_zero, i_clk, i_rst_n, not_ok, fields_zero, "error result with nonzero fields")
    // an ok result always has a nonzero area
    `PCC_ASSERT_NOW(a_ok_area, i_clk, i_rst_n, is_ok, o_area_doubled != '0, "ok result with zero area")
    // a taken result clears the valid flag and the back end returns to accumulating, so results never come back to back
    `PCC_ASSERT_NEXT(a_no_b2b, i_clk, i_rst_n, out_taken, !o_out_valid, "result right after a taken one")

endmodule

bind polygon_centroid_core pcc_checker u_pcc_checker (.*);

### tb/sv/polygon_centroid_core_test.sv
// Self-checking testbench of polygon_centroid_core: vertex streams in, centroid results checked.
module polygon_centroid_core_test;
    import pcc_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES   = 300;
    localparam int PRINT_LIMIT    = 40;

    typedef struct packed {
        logic signed [COORD_W-1:0] cx;
        logic signed [COORD_W-1:0] cy;
        logic signed [AREA_W-1:0]  area;
        logic [STATUS_W-1:0]       status;
    } t_centroid_result;

    typedef enum int {SHAPE_FULL, SHAPE_SMALL, SHAPE_EXTREME, SHAPE_LINE, SHAPE_CLUSTER} t_shape;
    typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} t_stall_mode;

    logic                      i_clk = 1'b0;
    logic                      i_rst_n;
    logic                      i_in_valid;
    logic                      o_in_stall;
    logic signed [COORD_W-1:0] i_vertex_x;
    logic signed [COORD_W-1:0] i_vertex_y;
    logic                      i_last;
    logic                      o_out_valid;
    logic                      i_out_stall;
    logic signed [COORD_W-1:0] o_centroid_x;
    logic signed [COORD_W-1:0] o_centroid_y;
    logic signed [AREA_W-1:0]  o_area_doubled;
    logic [STATUS_W-1:0]       o_status;

    polygon_centroid_core u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_vertex_x     (i_vertex_x),
        .i_vertex_y     (i_vertex_y),
        .i_last         (i_last),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_centroid_x   (o_centroid_x),
        .o_centroid_y   (o_centroid_y),
        .o_area_doubled (o_area_doubled),
        .o_status       (o_status)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Polygon accumulator mirror
    logic signed [COORD_W-1:0] poly_first_x = '0;
    logic signed [COORD_W-1:0] poly_first_y = '0;
    logic signed [COORD_W-1:0] poly_prev_x  = '0;
    logic signed [COORD_W-1:0] poly_prev_y  = '0;
    longint                    area_acc     = 0;
    longint                    wx_acc       = 0;
    longint                    wy_acc       = 0;
    int                        held_count   = 0;

    t_centroid_result centroid_expected [$];
    t_centroid_result next_centroid;

    logic signed [COORD_W-1:0] extreme_coords [0:7] = '{
        16'h8000, 16'h8001, 16'hFFFF, 16'h0000, 16'h0001, 16'h4000, 16'h7FFE, 16'h7FFF
    };

    int error_count    = 0;
    int results_seen   = 0;
    int vertices_sent  = 0;
    int polygons_sent  = 0;
    int ok_count       = 0;
    int saturated_count = 0;
    int zero_count     = 0;
    int overflow_count = 0;
    int burst_left     = 0;
    int hold_request   = 0;

    function automatic void accumulate_edge(input logic signed [COORD_W-1:0] xa,
                                            input logic signed [COORD_W-1:0] ya,
                                            input logic signed [COORD_W-1:0] xb,
                                            input logic signed [COORD_W-1:0] yb);
        longint cross_prod;
        cross_prod = longint'(xa) * longint'(yb) - longint'(xb) * longint'(ya);
        area_acc += cross_prod;
        wx_acc   += (longint'(xa) + longint'(xb)) * cross_prod;
        wy_acc   += (longint'(ya) + longint'(yb)) * cross_prod;
    endfunction

    function automatic logic signed [COORD_W-1:0] clamp_quotient(input longint sum,
                                                                 input longint div);
        longint q;
        q = sum / div;
        if (q > 32767)
            q = 32767;
        else if (q < -32768)
            q = -32768;
        return q[COORD_W-1:0];
    endfunction

    // Advance the polygon mirror by one vertex; returns 1 when a result is due.
    function automatic bit predict_vertex(input logic signed [COORD_W-1:0] x,
                                          input logic signed [COORD_W-1:0] y,
                                          input logic last_flag,
                                          output t_centroid_result res);
        longint div;
        res = '0;
        if (held_count < MAX_VERTICES) begin
            if (held_count == 0) begin
                poly_first_x = x;
                poly_first_y = y;
            end else begin
                accumulate_edge(poly_prev_x, poly_prev_y, x, y);
            end
            poly_prev_x = x;
            poly_prev_y = y;
            held_count++;
        end else begin
            held_count = MAX_VERTICES + 1;
        end
        if (!last_flag)
            return 1'b0;
        if (held_count > MAX_VERTICES) begin
            res.status = STATUS_OVERFLOW;
        end else begin
            accumulate_edge(poly_prev_x, poly_prev_y, poly_first_x, poly_first_y);
            if (area_acc == 0) begin
                res.status = STATUS_ZERO_AREA;
            end else begin
                div        = area_acc * 3;
                res.cx     = clamp_quotient(wx_acc, div);
                res.cy     = clamp_quotient(wy_acc, div);
                res.area   = area_acc[AREA_W-1:0];
                res.status = STATUS_OK;
            end
        end
        poly_first_x = '0;
        poly_first_y = '0;
        poly_prev_x  = '0;
        poly_prev_y  = '0;
        area_acc     = 0;
        wx_acc       = 0;
        wy_acc       = 0;
        held_count   = 0;
        return 1'b1;
    endfunction

    function automatic logic signed [COORD_W-1:0] pick_coord(input t_shape shape,
                                                             input logic signed [COORD_W-1:0] anchor);
        logic signed [COORD_W-1:0] v;
        case (shape)
            SHAPE_SMALL:   v = 16'($urandom_range(0, 127)) - 16'sd64;
            SHAPE_EXTREME: v = extreme_coords[$urandom_range(0, 7)];
            SHAPE_CLUSTER: v = anchor + 16'($urandom_range(0, 255)) - 16'sd128;
            default:       v = 16'($urandom_range(0, 65535));
        endcase
        return v;
    endfunction

    task automatic report_error(input string msg);
        error_count++;
        if (error_count <= PRINT_LIMIT)
            $display("ERROR: %s", msg);
    endtask

    task automatic send_vertex(input logic signed [COORD_W-1:0] x,
                               input logic signed [COORD_W-1:0] y,
                               input logic last_flag);
        t_centroid_result res;
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            repeat (gap) begin
                i_in_valid <= 1'b0;
                @(posedge i_clk);
            end
            burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                                     : $urandom_range(1, 20);
        end
        i_in_valid <= 1'b1;
        i_vertex_x <= x;
        i_vertex_y <= y;
        i_last     <= last_flag;
        do
            @(posedge i_clk);
        while (o_in_stall);
        burst_left--;
        vertices_sent++;
        if (last_flag)
            polygons_sent++;
        if (predict_vertex(x, y, last_flag, res))
            centroid_expected = {centroid_expected, res};
    endtask

    // Hold the input idle until every pending result is back.
    task automatic wait_results_drained();
        i_in_valid <= 1'b0;
        burst_left = 0;
        @(posedge i_clk);
        while (centroid_expected.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic test_single_vertex();
        send_vertex(16'h7FFF, 16'h8000, 1'b1);
        send_vertex(16'h0000, 16'h0000, 1'b1);
    endtask

    task automatic test_extreme_triangle();
        send_vertex(16'h8000, 16'h8000, 1'b0);
        send_vertex(16'h7FFF, 16'h8000, 1'b0);
        send_vertex(16'h7FFF, 16'h7FFF, 1'b1);
    endtask

    task automatic test_zero_area();
        // two-vertex polygon folds onto itself
        send_vertex(16'h8000, 16'h7FFF, 1'b0);
        send_vertex(16'h7FFF, 16'h8000, 1'b1);
        send_vertex(-16'sd100, -16'sd100, 1'b0);
        send_vertex(16'sd0, 16'sd0, 1'b0);
        send_vertex(16'sd100, 16'sd100, 1'b1);
    endtask

    task automatic test_saturation();
        // Two slivers of opposite orientation joined at the origin: net area nearly cancels.
        send_vertex(16'sd0, 16'sd0, 1'b0);
        send_vertex(16'sd32767, 16'sd0, 1'b0);
        send_vertex(16'sd32767, 16'sd2, 1'b0);
        send_vertex(16'sd0, 16'sd0, 1'b0);
        send_vertex(-16'sd32767, 16'sd1, 1'b0);
        send_vertex(-16'sd32766, 16'sd3, 1'b1);
    endtask

    task automatic test_clockwise_square();
        send_vertex(-16'sd1000, -16'sd1000, 1'b0);
        send_vertex(-16'sd1000, 16'sd1000, 1'b0);
        send_vertex(16'sd1000, 16'sd1000, 1'b0);
        send_vertex(16'sd1000, -16'sd1000, 1'b1);
    endtask

    task automatic test_vertex_limit();
        int i;
        // the last vertex arrives with the count already full
        for (i = 0; i < MAX_VERTICES + 1; i++)
            send_vertex(pick_coord(SHAPE_FULL, '0), pick_coord(SHAPE_FULL, '0),
                        i == MAX_VERTICES);
    endtask

    task automatic test_backpressure();
        int p;
        int v;
        // Hold the result side off long enough for the edge queue to fill.
        hold_request = 400;
        for (p = 0; p < 6; p++)
            for (v = 0; v < 8; v++)
                send_vertex(pick_coord(SHAPE_FULL, '0), pick_coord(SHAPE_FULL, '0), v == 7);
        wait_results_drained();
    endtask

    task automatic test_random_polygons(input int target);
        int sent;
        int len;
        int v;
        int sel;
        t_shape shape;
        logic signed [COORD_W-1:0] anchor_x;
        logic signed [COORD_W-1:0] anchor_y;
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        sent = 0;
        while (sent < target) begin
            sel = $urandom_range(0, 99);
            if (sel < 75)
                len = $urandom_range(1, 6);
            else if (sel < 97)
                len = $urandom_range(7, 30);
            else
                len = $urandom_range(31, 100);
            sel = $urandom_range(0, 99);
            if (sel < 40)
                shape = SHAPE_FULL;
            else if (sel < 60)
                shape = SHAPE_SMALL;
            else if (sel < 75)
                shape = SHAPE_EXTREME;
            else if (sel < 85)
                shape = SHAPE_LINE;
            else
                shape = SHAPE_CLUSTER;
            anchor_x = pick_coord(SHAPE_FULL, '0);
            anchor_y = pick_coord(SHAPE_FULL, '0);
            for (v = 0; v < len; v++) begin
                x = pick_coord(shape, anchor_x);
                y = (shape == SHAPE_LINE) ? anchor_y : pick_coord(shape, anchor_y);
                // repeat a vertex now and then
                if (v != 0 && $urandom_range(0, 19) == 0) begin
                    x = i_vertex_x;
                    y = i_vertex_y;
                end
                send_vertex(x, y, v == len - 1);
            end
            sent += len;
            if ($urandom_range(0, 24) == 0)
                wait_results_drained();
        end
    endtask

    initial begin
        i_rst_n    <= 1'b0;
        i_in_valid <= 1'b0;
        i_vertex_x <= '0;
        i_vertex_y <= '0;
        i_last     <= 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_single_vertex();
        test_extreme_triangle();
        test_zero_area();
        test_saturation();
        test_clockwise_square();
        wait_results_drained();
        test_vertex_limit();
        test_backpressure();
        test_random_polygons(200);

        wait_results_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("covered %0d vertices in %0d polygons, incl. one polygon over the vertex limit",
                 vertices_sent, polygons_sent);
        $display("results: %0d ok (%0d saturated), %0d zero area, %0d over limit, %0d errors",
                 ok_count, saturated_count, zero_count, overflow_count, error_count);
        if (error_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    initial begin : result_stall_driver
        t_stall_mode mode;
        int mode_left;
        int hold_left;
        int phase;
        i_out_stall <= 1'b0;
        mode      = STALL_NONE;
        mode_left = 0;
        hold_left = 0;
        phase     = 0;
        forever begin
            @(posedge i_clk);
            if (hold_request != 0) begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left != 0) begin
                i_out_stall <= 1'b1;
                hold_left--;
            end else begin
                if (mode_left == 0) begin
                    mode      = t_stall_mode'($urandom_range(0, 3));
                    mode_left = $urandom_range(20, 300);
                end
                mode_left--;
                phase++;
                case (mode)
                    STALL_NONE:  i_out_stall <= 1'b0;
                    STALL_LIGHT: i_out_stall <= ($urandom_range(0, 3) == 0);
                    STALL_HEAVY: i_out_stall <= ($urandom_range(0, 9) < 7);
                    default:     i_out_stall <= ((phase % 7) < 3);
                endcase
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            results_seen++;
            if (centroid_expected.size() == 0) begin
                report_error($sformatf("result %0d arrived with nothing expected", results_seen));
            end else begin
                next_centroid = centroid_expected.pop_front();
                if (o_centroid_x !== next_centroid.cx)
                    report_error($sformatf("result %0d centroid_x: got %0d, expected %0d",
                                           results_seen, o_centroid_x, next_centroid.cx));
                if (o_centroid_y !== next_centroid.cy)
                    report_error($sformatf("result %0d centroid_y: got %0d, expected %0d",
                                           results_seen, o_centroid_y, next_centroid.cy));
                if (o_area_doubled !== next_centroid.area)
                    report_error($sformatf("result %0d area_doubled: got %0d, expected %0d",
                                           results_seen, o_area_doubled, next_centroid.area));
                if (o_status !== next_centroid.status)
                    report_error($sformatf("result %0d status: got %0d, expected %0d",
                                           results_seen, o_status, next_centroid.status));
            end
            if (o_status == STATUS_OK) begin
                ok_count++;
                if (o_centroid_x == 16'h7FFF || o_centroid_x == 16'h8000 ||
                    o_centroid_y == 16'h7FFF || o_centroid_y == 16'h8000)
                    saturated_count++;
            end else if (o_status == STATUS_ZERO_AREA) begin
                zero_count++;
            end else if (o_status == STATUS_OVERFLOW) begin
                overflow_count++;
            end
        end
    end

    initial begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("watchdog: no request accepted for %0d cycles", WATCHDOG_LIMIT);
        $display("end of test: mismatches");
        $finish;
    end

endmodule
